// ----- rtl/lwm_pkg.sv -----
// ----------------------------------------------------------------------------
// lwm_pkg
// Shared types and constants for the LIKE wildcard matcher.
// ----------------------------------------------------------------------------
package lwm_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 8;

  typedef enum logic [1:0] {
    REQ_PATTERN_BYTE = 2'd0,
    REQ_TEXT_BYTE    = 2'd1,
    REQ_END_PATTERN  = 2'd2,
    REQ_END_TEXT     = 2'd3
  } lwm_req_t;

  localparam logic [CHAR_W-1:0] CH_ANY_RUN = 8'h25;
  localparam logic [CHAR_W-1:0] CH_ANY_ONE = 8'h5F;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP,
    ST_TFETCH,
    ST_TSTEP,
    ST_FINISH
  } lwm_state_t;

endpackage

// ----- rtl/lwm_ram.sv -----
// ----------------------------------------------------------------------------
// lwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sql_like_wildcard_matcher_top.sv -----
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher_top
// LIKE pattern matcher: '%' matches any run, '_' matches one byte.
// ----------------------------------------------------------------------------
// Pattern and text bytes are written one per cycle, while in_tready is high,
// into two 64-entry RAMs. An end-of-text request starts a greedy two-pointer
// match with backtracking to the last '%', run by a small sequencer around one
// byte comparator. Each match step is a registered RAM read, then a compare;
// an overflowed request skips the match and goes straight to the result.
// in_tready is low while a match runs. The result sits in an output register,
// so a new request is taken while it waits. The pattern stays stored across
// texts; the text store is emptied after every result.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] matched, [7:1] zero
  output logic [0:0] out_tuser   // [0] overflow
);

  import lwm_pkg::*;

  lwm_state_t state_r, state_nxt;

  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;
  logic             povf_r, povf_nxt;
  logic             tovf_r, tovf_nxt;
  logic             loading_r, loading_nxt;

  logic [LEN_W-1:0] p_r, p_nxt;
  logic [LEN_W-1:0] t_r, t_nxt;
  logic [LEN_W-1:0] run_p_r, run_p_nxt;
  logic [LEN_W-1:0] run_t_r, run_t_nxt;
  logic             have_run_r, have_run_nxt;
  logic             res_match_r, res_match_nxt;
  logic             res_ovf_r, res_ovf_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r, out_match_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic              in_acc;
  lwm_req_t          req;
  logic              out_free;
  logic              fin_load;
  logic              pat_we, txt_we;
  logic [ADDR_W-1:0] pat_waddr, txt_waddr;
  logic [CHAR_W-1:0] pat_rd, txt_rd;
  logic              p_lt, t_done, ch_eq;

  assign req      = lwm_req_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign p_lt     = p_r < plen_r;
  assign t_done   = t_r >= tlen_r;
  assign ch_eq    = (pat_rd == CH_ANY_ONE) || (pat_rd == txt_rd);

  // pattern and text stores
  assign pat_waddr = loading_r ? plen_r[ADDR_W-1:0] : '0;
  assign pat_we    = in_acc && (req == REQ_PATTERN_BYTE) &&
                     (!loading_r || (plen_r < LEN_W'(MAX_LEN)));
  assign txt_waddr = tlen_r[ADDR_W-1:0];
  assign txt_we    = in_acc && (req == REQ_TEXT_BYTE) && (tlen_r < LEN_W'(MAX_LEN));

  lwm_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (in_tdata),
    .raddr (p_r[ADDR_W-1:0]),
    .rdata (pat_rd)
  );

  lwm_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_txt_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_waddr),
    .wdata (in_tdata),
    .raddr (t_r[ADDR_W-1:0]),
    .rdata (txt_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (req == REQ_END_TEXT)) begin
          state_nxt = (povf_r || tovf_r) ? ST_FINISH : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = t_done ? ST_TFETCH : ST_STEP;
      end
      ST_STEP: begin
        if (p_lt && ch_eq) begin
          state_nxt = ST_FETCH;
        end else if (p_lt && (pat_rd == CH_ANY_RUN)) begin
          state_nxt = ST_FETCH;
        end else if (have_run_r) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_TFETCH: begin
        state_nxt = p_lt ? ST_TSTEP : ST_FINISH;
      end
      ST_TSTEP: begin
        state_nxt = (pat_rd == CH_ANY_RUN) ? ST_TFETCH : ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    fin_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_FINISH: fin_load  = out_free;
      default: begin
        in_tready = 1'b0;
        fin_load  = 1'b0;
      end
    endcase
  end

  // match datapath
  always_comb begin
    p_nxt         = p_r;
    t_nxt         = t_r;
    run_p_nxt     = run_p_r;
    run_t_nxt     = run_t_r;
    have_run_nxt  = have_run_r;
    res_match_nxt = res_match_r;
    res_ovf_nxt   = res_ovf_r;
    case (state_r)
      ST_IDLE: begin
        p_nxt         = '0;
        t_nxt         = '0;
        run_p_nxt     = '0;
        run_t_nxt     = '0;
        have_run_nxt  = 1'b0;
        res_match_nxt = 1'b0;
        res_ovf_nxt   = povf_r || tovf_r;
      end
      ST_STEP: begin
        if (p_lt && ch_eq) begin
          p_nxt = p_r + LEN_W'(1);
          t_nxt = t_r + LEN_W'(1);
        end else if (p_lt && (pat_rd == CH_ANY_RUN)) begin
          have_run_nxt = 1'b1;
          run_p_nxt    = p_r;
          run_t_nxt    = t_r;
          p_nxt        = p_r + LEN_W'(1);
        end else if (have_run_r) begin
          p_nxt     = run_p_r + LEN_W'(1);
          run_t_nxt = run_t_r + LEN_W'(1);
          t_nxt     = run_t_r + LEN_W'(1);
        end else begin
          res_match_nxt = 1'b0;
        end
      end
      ST_TFETCH: begin
        if (!p_lt) begin
          res_match_nxt = 1'b1;
        end
      end
      ST_TSTEP: begin
        if (pat_rd == CH_ANY_RUN) begin
          p_nxt = p_r + LEN_W'(1);
        end else begin
          res_match_nxt = 1'b0;
        end
      end
      default: begin
        p_nxt = p_r;
      end
    endcase
  end

  // store bookkeeping and output register
  always_comb begin
    plen_nxt      = plen_r;
    tlen_nxt      = tlen_r;
    povf_nxt      = povf_r;
    tovf_nxt      = tovf_r;
    loading_nxt   = loading_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_match_nxt = out_match_r;
    out_ovf_nxt   = out_ovf_r;
    if (in_acc) begin
      case (req)
        REQ_PATTERN_BYTE: begin
          loading_nxt = 1'b1;
          if (!loading_r) begin
            povf_nxt = 1'b0;
            plen_nxt = LEN_W'(1);
          end else if (plen_r < LEN_W'(MAX_LEN)) begin
            plen_nxt = plen_r + LEN_W'(1);
          end else begin
            povf_nxt = 1'b1;
          end
        end
        REQ_TEXT_BYTE: begin
          if (tlen_r < LEN_W'(MAX_LEN)) begin
            tlen_nxt = tlen_r + LEN_W'(1);
          end else begin
            tovf_nxt = 1'b1;
          end
        end
        REQ_END_PATTERN: begin
          if (!loading_r) begin
            plen_nxt = '0;
            povf_nxt = 1'b0;
          end
          loading_nxt = 1'b0;
        end
        default: begin
          loading_nxt = loading_r;
        end
      endcase
    end
    if (fin_load) begin
      tlen_nxt      = '0;
      tovf_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_match_nxt = res_match_r && !res_ovf_r;
      out_ovf_nxt   = res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      tlen_r      <= '0;
      povf_r      <= 1'b0;
      tovf_r      <= 1'b0;
      loading_r   <= 1'b0;
      have_run_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      tlen_r      <= tlen_nxt;
      povf_r      <= povf_nxt;
      tovf_r      <= tovf_nxt;
      loading_r   <= loading_nxt;
      have_run_r  <= have_run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    t_r         <= t_nxt;
    run_p_r     <= run_p_nxt;
    run_t_r     <= run_t_nxt;
    res_match_r <= res_match_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_match_r};
  assign out_tuser  = out_ovf_r;

  // checks
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tdata[0])
    else $error("match reported together with overflow");

  a_p_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) || (state_r == ST_TFETCH) || (state_r == ST_TSTEP))
      |-> (p_r <= plen_r))
    else $error("pattern pointer past pattern length");

  a_run_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (have_run_r && (state_r == ST_STEP)) |-> ((run_t_r <= t_r) && (run_p_r < p_r)))
    else $error("backtrack point ahead of match pointers");

  a_text_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |=> ((tlen_r == '0) && !tovf_r && out_tvalid))
    else $error("text store not emptied after result");

endmodule

// ----- dv/sql_like_wildcard_matcher_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher_top_tb
// Self-checking bench for the LIKE wildcard matcher.
// ----------------------------------------------------------------------------
// Drives pattern, text and end-of-string requests. A behavioral predictor
// tracks both stores and runs the greedy backtracking match on every
// end-of-text request without overflow. Each response is compared with the
// oldest predicted one. Directed cases come first, then random traffic built
// mostly from well-formed pattern/text sequences, with texts often derived
// from the stored pattern. The random traffic runs under several idle and
// stall mixes; one test with a long receiver hold-off runs between them.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher_top_tb;
  import lwm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic matched;
    logic overflow;
  } like_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] char_byte
  logic [1:0] in_tuser = 2'd0;    // [1:0] req_type
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] matched, [7:1] zero
  logic [0:0] out_tuser;          // [0] overflow

  // predictor state
  logic [7:0]   pat_mem [MAX_LEN];
  int           pat_len = 0;
  bit           pat_ovf = 1'b0;
  bit           pat_open = 1'b0;
  logic [7:0]   txt_mem [MAX_LEN];
  int           txt_len = 0;
  bit           txt_ovf = 1'b0;
  like_result_t pending_results [$];

  logic [7:0] str_buf [$];
  int         reqs_sent = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  int         rcv_hold = 0;

  sql_like_wildcard_matcher_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic logic like_eval();
    int p = 0;
    int t = 0;
    int run_p = 0;
    int run_t = 0;
    bit have_run = 1'b0;
    while (t < txt_len) begin
      if (p < pat_len && (pat_mem[p] == CH_ANY_ONE || pat_mem[p] == txt_mem[t])) begin
        p++;
        t++;
      end else if (p < pat_len && pat_mem[p] == CH_ANY_RUN) begin
        have_run = 1'b1;
        run_p = p;
        run_t = t;
        p++;
      end else if (have_run) begin
        p = run_p + 1;
        run_t++;
        t = run_t;
      end else begin
        return 1'b0;
      end
    end
    while (p < pat_len && pat_mem[p] == CH_ANY_RUN) p++;
    return (p == pat_len);
  endfunction

  function automatic void predict_req(lwm_req_t kind, logic [7:0] ch);
    like_result_t res;
    case (kind)
      REQ_PATTERN_BYTE: begin
        if (!pat_open) begin
          pat_len = 0;
          pat_ovf = 1'b0;
          pat_open = 1'b1;
        end
        if (pat_len < MAX_LEN) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      REQ_TEXT_BYTE: begin
        if (txt_len < MAX_LEN) begin
          txt_mem[txt_len] = ch;
          txt_len++;
        end else begin
          txt_ovf = 1'b1;
        end
      end
      REQ_END_PATTERN: begin
        if (!pat_open) begin
          pat_len = 0;
          pat_ovf = 1'b0;
        end
        pat_open = 1'b0;
      end
      default: begin
        res.overflow = pat_ovf | txt_ovf;
        res.matched = res.overflow ? 1'b0 : like_eval();
        pending_results.push_back(res);
        txt_len = 0;
        txt_ovf = 1'b0;
      end
    endcase
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    like_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: matched=%0b overflow=%0b", out_tdata[0], out_tuser[0]);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[0] !== exp_res.matched) begin
          $error("matched: expected %0b, got %0b", exp_res.matched, out_tdata[0]);
          fail_cnt++;
        end
        if (out_tuser[0] !== exp_res.overflow) begin
          $error("overflow: expected %0b, got %0b", exp_res.overflow, out_tuser[0]);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rcv_hold > 0) begin
      out_tready <= 1'b0;
      rcv_hold--;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---------------- request driver ----------------
  task automatic send_req(input lwm_req_t kind, input logic [7:0] ch);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_req(kind, ch);
    reqs_sent++;
  endtask

  task automatic send_buf(input lwm_req_t kind);
    for (int i = 0; i < str_buf.size(); i++) send_req(kind, str_buf[i]);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_char();
    if ($urandom_range(99) < 15) return any_byte();
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pattern_char();
    int r = $urandom_range(99);
    if (r < 30) return CH_ANY_RUN;
    if (r < 45) return CH_ANY_ONE;
    if (r < 85) return 8'("a" + $urandom_range(0, 2));
    return any_byte();
  endfunction

  function automatic int rand_len(int short_max);
    if ($urandom_range(99) < 8) return $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
    return $urandom_range(0, short_max);
  endfunction

  function automatic void build_pattern();
    int n = rand_len(10);
    str_buf.delete();
    for (int i = 0; i < n; i++) str_buf.push_back(pattern_char());
  endfunction

  // text either free-form or shaped after the stored pattern
  function automatic void build_text();
    int n;
    str_buf.delete();
    if (pat_len > 0 && $urandom_range(99) < 55) begin
      for (int i = 0; i < pat_len; i++) begin
        if (pat_mem[i] == CH_ANY_RUN) begin
          n = $urandom_range(0, 3);
          for (int k = 0; k < n; k++) str_buf.push_back(text_char());
        end else if (pat_mem[i] == CH_ANY_ONE) begin
          str_buf.push_back(text_char());
        end else begin
          str_buf.push_back(pat_mem[i]);
        end
      end
      if (str_buf.size() > 0 && $urandom_range(99) < 20)
        str_buf[$urandom_range(0, str_buf.size() - 1)] = text_char();
    end else begin
      n = rand_len(12);
      for (int i = 0; i < n; i++) str_buf.push_back(text_char());
    end
  endfunction

  task automatic send_text_and_end();
    build_text();
    send_buf(REQ_TEXT_BYTE);
    send_req(REQ_END_TEXT, any_byte());
  endtask

  // ---------------- tests ----------------
  task automatic test_empty_strings();
    send_req(REQ_END_PATTERN, any_byte());
    send_req(REQ_END_TEXT, any_byte());
    send_req(REQ_TEXT_BYTE, "x");
    send_req(REQ_END_TEXT, any_byte());
  endtask

  task automatic test_wildcards();
    send_req(REQ_PATTERN_BYTE, CH_ANY_RUN);
    send_req(REQ_PATTERN_BYTE, CH_ANY_ONE);
    send_req(REQ_PATTERN_BYTE, "z");
    send_req(REQ_END_PATTERN, any_byte());
    send_req(REQ_TEXT_BYTE, "a");
    send_req(REQ_TEXT_BYTE, "b");
    send_req(REQ_TEXT_BYTE, "z");
    send_req(REQ_END_TEXT, any_byte());
    send_req(REQ_TEXT_BYTE, "z");
    send_req(REQ_END_TEXT, any_byte());
  endtask

  task automatic test_extreme_bytes();
    send_req(REQ_PATTERN_BYTE, 8'h00);
    send_req(REQ_PATTERN_BYTE, 8'hFF);
    send_req(REQ_END_PATTERN, 8'hFF);
    send_req(REQ_TEXT_BYTE, 8'h00);
    send_req(REQ_TEXT_BYTE, 8'hFF);
    send_req(REQ_END_TEXT, 8'h00);
  endtask

  task automatic test_text_during_pattern();
    send_req(REQ_PATTERN_BYTE, "q");
    send_req(REQ_TEXT_BYTE, "q");
    send_req(REQ_END_TEXT, any_byte());
    send_req(REQ_PATTERN_BYTE, CH_ANY_RUN);
    send_req(REQ_END_PATTERN, any_byte());
    send_req(REQ_END_TEXT, any_byte());
  endtask

  // receiver holds off while short texts keep coming; input must stall
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    rcv_hold = 3000;
    for (int i = 0; i < 8; i++) begin
      send_req(REQ_TEXT_BYTE, text_char());
      send_req(REQ_END_TEXT, any_byte());
    end
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int n_reqs);
    int stop_at = reqs_sent + n_reqs;
    int r;
    int n;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    while (reqs_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 25) begin
        build_pattern();
        send_buf(REQ_PATTERN_BYTE);
        send_req(REQ_END_PATTERN, any_byte());
      end else if (r < 80) begin
        send_text_and_end();
      end else if (r < 88) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_req(REQ_PATTERN_BYTE, pattern_char());
        send_text_and_end();
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) send_req(REQ_PATTERN_BYTE, pattern_char());
        send_req(REQ_END_PATTERN, any_byte());
      end else if (r < 93) begin
        send_req(REQ_END_PATTERN, any_byte());
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_req(lwm_req_t'($urandom_range(0, 3)), any_byte());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_strings();
    test_wildcards();
    test_extreme_bytes();
    test_text_during_pattern();
    test_random(0, 0, 460);
    test_random(66, 0, 460);
    test_backpressure();
    test_random(0, 66, 460);
    test_random(33, 33, 460);
    in_tvalid <= 1'b0;
    rcv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
